>>> src/ctc_pkg.sv
// Package for the calendar time counter: payload structs, limits and
// calendar helper functions. No dependencies.
package ctc_pkg;

    localparam logic [3:0] C_MONTH_MAX  = 4'd12;
    localparam logic [4:0] C_HOUR_MAX   = 5'd23;
    localparam logic [5:0] C_MINSEC_MAX = 6'd59;
    localparam logic [4:0] C_LEN_FEB    = 5'd28;
    localparam logic [4:0] C_LEN_SHORT  = 5'd30;
    localparam logic [4:0] C_LEN_LONG   = 5'd31;

    localparam logic [3:0] C_FEB = 4'd2;
    localparam logic [3:0] C_APR = 4'd4;
    localparam logic [3:0] C_JUN = 4'd6;
    localparam logic [3:0] C_SEP = 4'd9;
    localparam logic [3:0] C_NOV = 4'd11;

    localparam logic C_REQ_TICK = 1'b0;
    localparam logic C_REQ_SET  = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [3:0] new_month;
        logic [4:0] new_day;
        logic [4:0] new_hour;
        logic [5:0] new_minute;
        logic [5:0] new_second;
    } t_in;

    typedef struct packed {
        logic [3:0] cur_month;
        logic [4:0] cur_day;
        logic [4:0] cur_hour;
        logic [5:0] cur_minute;
        logic [5:0] cur_second;
        logic       in_range;
    } t_out;

    typedef struct packed {
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_time;

    localparam t_time C_RESET_TIME = '{month: 4'd1, day: 5'd1, hour: 5'd0,
                                       minute: 6'd0, second: 6'd0};

    function automatic logic [4:0] month_length(input logic [3:0] m);
        logic [4:0] len;
        if (m == C_FEB) begin
            len = C_LEN_FEB;
        end else if (m == C_APR || m == C_JUN || m == C_SEP || m == C_NOV) begin
            len = C_LEN_SHORT;
        end else begin
            len = C_LEN_LONG;
        end
        return len;
    endfunction

    function automatic logic fields_ok(input t_time t);
        return (t.month != 4'd0) && (t.month <= C_MONTH_MAX) && (t.day != 5'd0) &&
               (t.hour <= C_HOUR_MAX) && (t.minute <= C_MINSEC_MAX) &&
               (t.second <= C_MINSEC_MAX);
    endfunction

endpackage

>>> src/ctc_next.sv
// Next-value logic for the calendar time counter: applies one tick or set
// to the stored time and forms the result beat. Depends on ctc_pkg.
module ctc_next (
    input  ctc_pkg::t_time i_time,
    input  ctc_pkg::t_in   i_item,
    output ctc_pkg::t_time o_time,
    output ctc_pkg::t_out  o_result
);
    import ctc_pkg::*;

    logic [4:0] w_len;
    t_time      w_t;

    assign w_len = month_length(i_time.month);

    always_comb begin
        w_t = i_time;
        if (i_item.req_type == C_REQ_SET) begin
            w_t.month  = i_item.new_month;
            w_t.day    = i_item.new_day;
            w_t.hour   = i_item.new_hour;
            w_t.minute = i_item.new_minute;
            w_t.second = i_item.new_second;
        end else if (fields_ok(i_time)) begin
            if (i_time.second != C_MINSEC_MAX) begin
                w_t.second = 6'(i_time.second + 6'd1);
            end else begin
                w_t.second = 6'd0;
                if (i_time.minute != C_MINSEC_MAX) begin
                    w_t.minute = 6'(i_time.minute + 6'd1);
                end else begin
                    w_t.minute = 6'd0;
                    if (i_time.hour != C_HOUR_MAX) begin
                        w_t.hour = 5'(i_time.hour + 5'd1);
                    end else begin
                        w_t.hour = 5'd0;
                        // a day past the month's end keeps the date frozen
                        if (i_time.day == w_len) begin
                            w_t.day   = 5'd1;
                            w_t.month = (i_time.month == C_MONTH_MAX) ? 4'd1
                                      : 4'(i_time.month + 4'd1);
                        end else if (i_time.day < w_len) begin
                            w_t.day = 5'(i_time.day + 5'd1);
                        end
                    end
                end
            end
        end
    end

    assign o_time = w_t;

    assign o_result.cur_month  = w_t.month;
    assign o_result.cur_day    = w_t.day;
    assign o_result.cur_hour   = w_t.hour;
    assign o_result.cur_minute = w_t.minute;
    assign o_result.cur_second = w_t.second;
    assign o_result.in_range   = fields_ok(w_t);

endmodule

>>> src/calendar_time_counter_top.sv
// Top level of the calendar time counter: input register, time registers
// and result register around ctc_next. Depends on ctc_pkg and ctc_next.
//
// Every accepted beat (tick or set) yields exactly one result beat carrying
// the month, day, hour, minute and second after that beat plus the range
// flag. The block takes one beat per clock cycle while the output is not
// stalled. A beat is held in the input register and its result beat is
// presented from the result register. A stalled output drops o_in_ready
// only once the input register also holds a beat. The time registers are
// updated in the same cycle as the result register, by a single pass of
// compare-and-increment logic, so each beat sees the value left by the one
// before it. Out of reset the stored time is month 1, day 1, 00:00:00.
module calendar_time_counter_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ctc_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ctc_pkg::t_out o_out_data
);
    import ctc_pkg::*;

    logic  r_in_valid;
    t_in   r_in;
    logic  r_out_valid;
    t_out  r_out;
    t_time r_time;

    t_time n_time;
    t_out  n_out;

    logic  w_out_free;
    logic  w_advance;
    logic  w_in_ready;

    ctc_next u_next (
        .i_time   (r_time),
        .i_item   (r_in),
        .o_time   (n_time),
        .o_result (n_out)
    );

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_advance  = r_in_valid && w_out_free;
    assign w_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_time      <= C_RESET_TIME;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (w_advance) begin
                r_time <= n_time;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_in_valid && w_in_ready) begin
            r_in <= i_in_data;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> src/ctc_checker.sv
// Port-level checks for the calendar time counter, bound to the top level.
// Depends on ctc_pkg.
module ctc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input ctc_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input ctc_pkg::t_out o_out_data
);
    import ctc_pkg::*;

    // a stalled result beat stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // the range flag agrees with the fields it reports on
    a_range_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.in_range ==
            ((o_out_data.cur_month != 4'd0) && (o_out_data.cur_month <= C_MONTH_MAX) &&
             (o_out_data.cur_day != 5'd0) && (o_out_data.cur_hour <= C_HOUR_MAX) &&
             (o_out_data.cur_minute <= C_MINSEC_MAX) &&
             (o_out_data.cur_second <= C_MINSEC_MAX))))
        else $error("range flag does not match result fields");

    // no result beat right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a set beat accepted into an empty block reports its own month and second;
    // the block is empty when no result is up and no beat was taken the cycle before
    a_set_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.req_type == C_REQ_SET) &&
        !o_out_valid && !$past(i_in_valid && o_in_ready) |=> ##1 (o_out_valid &&
            (o_out_data.cur_month == $past(i_in_data.new_month, 2)) &&
            (o_out_data.cur_second == $past(i_in_data.new_second, 2))))
        else $error("set beat not reflected in result");

endmodule

bind calendar_time_counter_top ctc_checker u_ctc_checker (.*);

>>> verif/calendar_time_checker.sv
// Checker for the calendar time counter: watches the input and result channels,
// keeps its own copy of the stored date and time, and compares every result beat.
// Depends on ctc_pkg for the payload types.
module calendar_time_checker
    import ctc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_data,
    output int   o_mismatches,
    output int   o_pending,
    output int   o_checked
);

    t_time stored_time;
    t_out  expected_readings[$];
    int    mismatch_count = 0;
    int    checked_count  = 0;

    function automatic logic [4:0] days_in(input logic [3:0] m);
        case (m)
            C_FEB: begin
                return C_LEN_FEB;
            end
            C_APR, C_JUN, C_SEP, C_NOV: begin
                return C_LEN_SHORT;
            end
            default: begin
                return C_LEN_LONG;
            end
        endcase
    endfunction

    function automatic logic time_plausible(input t_time t);
        return t.month >= 1 && t.month <= 12 && t.day >= 1 &&
               t.hour < 24 && t.minute < 60 && t.second < 60;
    endfunction

    // One second forward; anything out of range stays put, and a day past
    // the month length freezes the date while the time wraps.
    function automatic t_time next_second(input t_time t);
        t_time n;
        n = t;
        if (!time_plausible(t)) begin
            return t;
        end
        if (t.second != 59) begin
            n.second = t.second + 6'd1;
        end else begin
            n.second = '0;
            if (t.minute != 59) begin
                n.minute = t.minute + 6'd1;
            end else begin
                n.minute = '0;
                if (t.hour != 23) begin
                    n.hour = t.hour + 5'd1;
                end else begin
                    n.hour = '0;
                    if (t.day < days_in(t.month)) begin
                        n.day = t.day + 5'd1;
                    end else if (t.day == days_in(t.month)) begin
                        n.day   = 5'd1;
                        n.month = (t.month == 12) ? 4'd1 : t.month + 4'd1;
                    end
                end
            end
        end
        return n;
    endfunction

    function automatic int diff_field(input string label, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", label, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : track
        t_out want;
        int   bad;
        if (!i_rst_n) begin
            stored_time = C_RESET_TIME;
            expected_readings.delete();
            o_pending <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.req_type == C_REQ_SET) begin
                    stored_time.month  = i_in_data.new_month;
                    stored_time.day    = i_in_data.new_day;
                    stored_time.hour   = i_in_data.new_hour;
                    stored_time.minute = i_in_data.new_minute;
                    stored_time.second = i_in_data.new_second;
                end else begin
                    stored_time = next_second(stored_time);
                end
                want.cur_month  = stored_time.month;
                want.cur_day    = stored_time.day;
                want.cur_hour   = stored_time.hour;
                want.cur_minute = stored_time.minute;
                want.cur_second = stored_time.second;
                want.in_range   = time_plausible(stored_time);
                expected_readings.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_readings.size() == 0) begin
                    $error("result beat arrived with no reading outstanding");
                    mismatch_count++;
                end else begin
                    want = expected_readings.pop_front();
                    bad  = diff_field("cur_month", int'(want.cur_month),
                                      int'(i_out_data.cur_month));
                    bad += diff_field("cur_day", int'(want.cur_day),
                                      int'(i_out_data.cur_day));
                    bad += diff_field("cur_hour", int'(want.cur_hour),
                                      int'(i_out_data.cur_hour));
                    bad += diff_field("cur_minute", int'(want.cur_minute),
                                      int'(i_out_data.cur_minute));
                    bad += diff_field("cur_second", int'(want.cur_second),
                                      int'(i_out_data.cur_second));
                    bad += diff_field("in_range", int'(want.in_range),
                                      int'(i_out_data.in_range));
                    if (bad != 0) begin
                        mismatch_count++;
                    end
                    checked_count++;
                end
            end
            o_pending <= expected_readings.size();
        end
        o_mismatches <= mismatch_count;
        o_checked    <= checked_count;
    end

endmodule

>>> verif/tb_calendar_time_counter_top.sv
// Testbench top for calendar_time_counter_top: clock, reset, tick/set stimulus
// and ready stalls; checking is done by calendar_time_checker. Depends on ctc_pkg.
module tb_calendar_time_counter_top;
    import ctc_pkg::*;

    localparam int ITEM_TARGET = 1300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 4;

    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic out_ready = 1'b0;
    logic calm      = 1'b0;
    logic in_ready;
    logic out_valid;
    t_out out_data;

    int mismatches;
    int pending;
    int checked;
    int cycle_count = 0;
    int tick_count  = 0;
    int set_count   = 0;

    calendar_time_counter_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    calendar_time_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        out_ready <= calm || ($urandom_range(0, 99) >= 11);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d readings outstanding", cycle_count, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Returns at the edge where the beat is taken.
    task automatic send_beat(input t_in beat);
        while (!calm && $urandom_range(0, 99) < 11) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        if (beat.req_type == C_REQ_SET) begin
            set_count++;
        end else begin
            tick_count++;
        end
        @(posedge i_clk);
        while (!in_ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_tick();
        t_in beat;
        beat = 27'($urandom);    // payload is don't-care on a tick
        beat.req_type = C_REQ_TICK;
        send_beat(beat);
    endtask

    task automatic send_set(input logic [3:0] m, input logic [4:0] d, input logic [4:0] h,
                            input logic [5:0] mi, input logic [5:0] s);
        t_in beat;
        beat.req_type   = C_REQ_SET;
        beat.new_month  = m;
        beat.new_day    = d;
        beat.new_hour   = h;
        beat.new_minute = mi;
        beat.new_second = s;
        send_beat(beat);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Valid date/time biased toward month, day, hour and minute boundaries;
    // days above 28 also hit the frozen-date case in short months.
    task automatic send_boundary_set();
        logic [4:0] d;
        d = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(1, 31))
                                         : 5'($urandom_range(27, 31));
        send_set(4'($urandom_range(1, 12)), d,
                 $urandom_range(0, 1) ? 5'd23 : 5'($urandom_range(0, 23)),
                 $urandom_range(0, 1) ? 6'd59 : 6'($urandom_range(0, 59)),
                 $urandom_range(0, 1) ? 6'($urandom_range(55, 59)) : 6'($urandom_range(0, 59)));
    endtask

    initial begin : stimulus
        int   sent;
        int   run;
        int   roll;
        logic paused;
        t_in  beat;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset value, then each boundary and bad-field case with one tick
        send_tick();
        send_set(4'd12, 5'd31, 5'd23, 6'd59, 6'd59); send_tick();   // year wrap
        send_set(4'd2, 5'd28, 5'd23, 6'd59, 6'd59);  send_tick();   // end of February
        send_set(4'd4, 5'd30, 5'd23, 6'd59, 6'd59);  send_tick();   // end of 30-day month
        send_set(4'd1, 5'd31, 5'd23, 6'd59, 6'd59);  send_tick();
        send_set(4'd2, 5'd31, 5'd23, 6'd59, 6'd59);  send_tick();   // frozen date
        send_set(4'd11, 5'd31, 5'd23, 6'd59, 6'd59); send_tick();   // frozen, 30-day month
        send_set(4'd3, 5'd15, 5'd10, 6'd59, 6'd59);  send_tick();   // hour carry
        send_set(4'd0, 5'd0, 5'd0, 6'd0, 6'd0);      send_tick();   // month zero
        send_set(4'd15, 5'd31, 5'd31, 6'd63, 6'd63); send_tick();   // all ones
        send_set(4'd5, 5'd0, 5'd12, 6'd30, 6'd30);   send_tick();   // day zero
        send_set(4'd7, 5'd4, 5'd24, 6'd0, 6'd0);     send_tick();   // hour 24
        send_set(4'd8, 5'd8, 5'd12, 6'd60, 6'd10);   send_tick();   // minute 60
        send_set(4'd9, 5'd9, 5'd12, 6'd10, 6'd60);   send_tick();   // second 60
        wait_drained();

        sent   = 0;
        paused = 1'b0;
        while (sent < ITEM_TARGET) begin
            if (sent >= 500 && sent < 800) begin
                calm <= 1'b1;
            end else begin
                calm <= 1'b0;
            end
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                beat = 27'($urandom);
                send_beat(beat);
                sent++;
            end else if (roll < 15) begin
                run = $urandom_range(60, 130);
                repeat (run) send_tick();
                sent += run;
            end else begin
                send_boundary_set();
                run = $urandom_range(1, 6);
                repeat (run) send_tick();
                sent += run + 1;
            end
            if (!paused && sent >= 700) begin
                wait_drained();
                paused = 1'b1;
            end
        end
        calm <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d readings from %0d ticks and %0d sets: carries, month and year",
                 checked, tick_count, set_count);
        $display("ends, frozen dates past month length, and out-of-range stored values.");
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
